[rtl/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types for the positional list engine: request/result words, the
// action codes and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package ple_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT    = 2'd0,
    ACT_REMOVE    = 2'd1,
    ACT_READ      = 2'd2,
    ACT_OVERWRITE = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic [4:0]         count;
    logic               empty_res;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request word
    logic check;     // latch pass/fail, seed the walk index
    logic rd_en;     // read store entry
    logic wr_value;  // write request value at index
    logic wr_shift;  // write the entry just read one place over
    logic idx_step;  // advance the walk index
    logic cnt_inc;
    logic cnt_dec;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_t action;
    logic    ok_calc;    // request is legal against the current count
    logic    shift_more; // entries remain to be moved
  } dp_status_t;

endpackage

[rtl/ple_ctrl.sv]
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer for the list engine: check, entry moves, final read or write (where the action has one), result.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  input  ple_pkg::dp_status_t status,
  output ple_pkg::dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_STEP  = 5'b00100,
    S_MOVE  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = status.ok_calc ? S_STEP : S_RESP;
      end
      S_STEP: begin
        case (status.action)
          ple_pkg::ACT_READ: begin
            cmd.rd_en = 1'b1;
            state_nxt = S_RESP;
          end
          ple_pkg::ACT_OVERWRITE: begin
            cmd.wr_value = 1'b1;
            state_nxt    = S_RESP;
          end
          ple_pkg::ACT_INSERT: begin
            if (status.shift_more) begin
              cmd.rd_en = 1'b1;
              state_nxt = S_MOVE;
            end else begin
              cmd.wr_value = 1'b1;
              cmd.cnt_inc  = 1'b1;
              state_nxt    = S_RESP;
            end
          end
          ple_pkg::ACT_REMOVE: begin
            if (status.shift_more) begin
              cmd.rd_en = 1'b1;
              state_nxt = S_MOVE;
            end else begin
              cmd.cnt_dec = 1'b1;
              state_nxt   = S_RESP;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_MOVE: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_step = 1'b1;
        state_nxt    = S_STEP;
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/ple_datapath.sv]
// ----------------------------------------------------------------------------
// ple_datapath
// Request register, entry count, walk index and the entry store with its
// registered read port.
// ----------------------------------------------------------------------------
module ple_datapath #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ple_pkg::in_word_t   in_data,
  input  ple_pkg::dp_cmd_t    cmd,
  output ple_pkg::dp_status_t status,
  output ple_pkg::out_word_t  out_data
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

  ple_pkg::in_word_t      req_r;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          idx_r;
  logic                   ok_r;
  logic [VALUE_WIDTH-1:0] rdata_r;
  logic [VALUE_WIDTH-1:0] mem [CAPACITY];

  logic [CMPW-1:0]        pos_w, cnt_w, idx_w, pos_m1_w, cnt_out_w;
  logic                   ins, pos_nz, ok_calc;
  logic [CW-1:0]          idx_m1, idx_init;
  logic [AW-1:0]          raddr, waddr;
  logic [VALUE_WIDTH-1:0] store_word, wdata;
  logic [31:0]            rd32;

  assign ins      = (req_r.action == ple_pkg::ACT_INSERT);
  assign pos_w    = CMPW'(req_r.position);
  assign cnt_w    = CMPW'(count_r);
  assign idx_w    = CMPW'(idx_r);
  assign pos_m1_w = pos_w - CMPW'(1);
  assign pos_nz   = (pos_w != '0);

  always_comb begin
    if (ins) begin
      ok_calc = pos_nz && (pos_w <= cnt_w + CMPW'(1)) && (cnt_w < CMPW'(CAPACITY));
    end else begin
      ok_calc = pos_nz && (pos_w <= cnt_w);
    end
  end

  // insert walks down from the tail, remove walks up from the hole
  always_comb begin
    case (req_r.action)
      ple_pkg::ACT_INSERT: idx_init = count_r;
      ple_pkg::ACT_REMOVE: idx_init = pos_w[CW-1:0];
      default:             idx_init = pos_m1_w[CW-1:0];
    endcase
  end

  assign idx_m1 = idx_r - CW'(1);

  assign status.action     = req_r.action;
  assign status.ok_calc    = ok_calc;
  assign status.shift_more = ins ? (idx_w >= pos_w) : (idx_w < cnt_w);

  assign raddr = ins ? idx_m1[AW-1:0] : idx_r[AW-1:0];

  always_comb begin
    if (cmd.wr_shift) begin
      waddr = ins ? idx_r[AW-1:0] : idx_m1[AW-1:0];
      wdata = rdata_r;
    end else begin
      waddr = idx_r[AW-1:0];
      wdata = store_word;
    end
  end

  // 32-bit request word to stored width, stored width back to 32 bits
  generate
    if (VALUE_WIDTH > 32) begin : g_wide
      assign store_word = {{(VALUE_WIDTH-32){req_r.value[31]}}, req_r.value};
      assign rd32       = rdata_r[31:0];
    end else if (VALUE_WIDTH == 32) begin : g_equal
      assign store_word = req_r.value;
      assign rd32       = rdata_r;
    end else begin : g_narrow
      assign store_word = req_r.value[VALUE_WIDTH-1:0];
      assign rd32       = {{(32-VALUE_WIDTH){1'b0}}, rdata_r};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.check) begin
      idx_r <= idx_init;
    end else if (cmd.idx_step) begin
      idx_r <= ins ? idx_m1 : (idx_r + CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ok_r    <= 1'b0;
    end else begin
      if (cmd.check) begin
        ok_r <= ok_calc;
      end
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_value || cmd.wr_shift) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign cnt_out_w           = CMPW'(count_r);
  assign out_data.ok         = ok_r;
  assign out_data.read_value = (ok_r && (req_r.action == ple_pkg::ACT_READ)) ? rd32 : '0;
  assign out_data.count      = cnt_out_w[4:0];
  assign out_data.empty_res  = (count_r == '0);

endmodule

[rtl/positional_list_engine_top.sv]
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Each accepted word moves k entries (insert: count-pos+1, remove: count-pos,
//   read/overwrite: 0), none on a fail. Each move reads one entry and writes
//   it one place over. A new word is taken only once the previous result
//   has been given (busy low). The receiver cannot stall.
// Reset (rst_n low, synchronous): count zero, sequencer idle, no result.
// ----------------------------------------------------------------------------
module positional_list_engine_top #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ple_pkg::in_word_t  in_data,
  output logic               out_valid,
  output ple_pkg::out_word_t out_data
);

  // Controller sequences: IDLE -> CHECK -> (STEP/MOVE)* -> RESP -> IDLE.
  // CHECK latches pass/fail against the current count and seeds the index;
  // each MOVE shifts one entry, so the list stays packed at positions 1..count.
  // A failed request goes straight to RESP with nothing changed.

  ple_pkg::dp_cmd_t    cmd;
  ple_pkg::dp_status_t status;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  // Store entries are undefined until written; only positions 1..count are
  // ever read, and every one of those has been written.
  ple_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

[rtl/ple_checker.sv]
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks for the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input ple_pkg::out_word_t out_data
);

  // one result per word: out_valid is never held high
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

  // a result only comes from a word in flight
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result while idle");

  // accepting a word makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after accepted word");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.empty_res == (out_data.count == 5'd0)))
    else $error("empty flag disagrees with count");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.ok) |-> (out_data.read_value == 32'sd0))
    else $error("failed request returned data");

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
